/* hdl/rme_pkg.sv */
// Shared constants, types and control structures for the modular exponentiation core.
package rme_pkg;

  localparam int WIDTH = 16;
  localparam int EXP_WIDTH = 16;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int STEP_COUNT_WIDTH = $clog2(WIDTH);

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PUBLIC_EXPONENT = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRIVATE_EXPONENT = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODULUS = 2'd2;

  localparam logic [EXP_WIDTH-1:0] PUBLIC_EXPONENT_RESET = 16'd5;
  localparam logic [EXP_WIDTH-1:0] PRIVATE_EXPONENT_RESET = 16'd173;
  localparam logic [WIDTH-1:0] MODULUS_RESET = 16'd323;

  localparam logic ACTION_ENCRYPT = 1'b0;
  localparam logic ACTION_DECRYPT = 1'b1;

  typedef enum logic [1:0] {
    MUL_REDUCE,
    MUL_ACC,
    MUL_SQUARE
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    mul_sel_t mul_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic exp_zero;
    logic exp_lsb;
    logic mod_zero;
  } dp_status_t;

endpackage

/* hdl/rme_datapath.sv */
// Datapath: operand registers, exponent shifter and a bit-serial modular multiplier.
module rme_datapath (
  input  logic                                  clk,
  input  logic                                  rst,
  input  rme_pkg::dp_cmd_t                      cmd,
  output rme_pkg::dp_status_t                   status,
  input  logic [rme_pkg::EXP_WIDTH-1:0]         public_exponent,
  input  logic [rme_pkg::EXP_WIDTH-1:0]         private_exponent,
  input  logic [rme_pkg::WIDTH-1:0]             modulus,
  input  logic                                  action,
  input  logic [rme_pkg::WIDTH-1:0]             value,
  input  logic                                  last_in,
  output logic [rme_pkg::WIDTH-1:0]             result,
  output logic                                  last_out
);
  import rme_pkg::*;

  logic [WIDTH-1:0]            mod_q;
  logic [WIDTH-1:0]            value_q;
  logic [EXP_WIDTH-1:0]        expo;
  logic [WIDTH-1:0]            acc;
  logic [WIDTH-1:0]            base;
  logic                        last_q;

  logic [WIDTH-1:0]            mr;
  logic [WIDTH-1:0]            ma;
  logic [WIDTH-1:0]            mb;
  logic [STEP_COUNT_WIDTH-1:0] mcnt;
  logic                        mrun;
  mul_sel_t                    mdest;
  logic                        mul_done;

  logic [EXP_WIDTH-1:0]        expo_in;
  logic [WIDTH-1:0]            one_mod;
  logic [WIDTH-1:0]            sel_a;
  logic [WIDTH-1:0]            sel_b;
  logic [WIDTH:0]              dbl;
  logic [WIDTH:0]              dbl_red;
  logic [WIDTH:0]              sum;
  logic [WIDTH:0]              sum_red;
  logic [WIDTH:0]              mod_ext;
  logic [WIDTH-1:0]            step;

  assign expo_in = (action == ACTION_DECRYPT) ? private_exponent : public_exponent;
  assign one_mod = (mod_q == WIDTH'(1)) ? '0 : WIDTH'(1);
  assign mod_ext = {1'b0, mod_q};

  // One multiplier bit per cycle, most significant first: r = 2r + bit*a, kept below m.
  always_comb begin
    dbl     = {mr, 1'b0};
    dbl_red = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
    sum     = dbl_red + (mb[WIDTH-1] ? {1'b0, ma} : '0);
    sum_red = (sum >= mod_ext) ? sum - mod_ext : sum;
    step    = sum_red[WIDTH-1:0];
  end

  always_comb begin
    sel_a = base;
    sel_b = base;
    case (cmd.mul_sel)
      MUL_REDUCE: begin
        sel_a = one_mod;
        sel_b = value_q;
      end
      MUL_ACC: begin
        sel_a = base;
        sel_b = acc;
      end
      default: begin
        sel_a = base;
        sel_b = base;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mrun     <= 1'b0;
      mul_done <= 1'b0;
    end else begin
      mul_done <= 1'b0;
      if (cmd.mul_start) begin
        mrun <= 1'b1;
      end else if (mrun && (mcnt == STEP_COUNT_WIDTH'(WIDTH - 1))) begin
        mrun     <= 1'b0;
        mul_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_q   <= modulus;
      value_q <= value;
      expo    <= expo_in;
      last_q  <= last_in;
      // Exponent zero gives 1 for any modulus; otherwise start from 1 mod m.
      if (expo_in == '0) begin
        acc <= WIDTH'(1);
      end else if (modulus <= WIDTH'(1)) begin
        acc <= '0;
      end else begin
        acc <= WIDTH'(1);
      end
    end
    if (cmd.mul_start) begin
      ma    <= sel_a;
      mb    <= sel_b;
      mr    <= '0;
      mcnt  <= '0;
      mdest <= cmd.mul_sel;
    end else if (mrun) begin
      mr   <= step;
      mb   <= {mb[WIDTH-2:0], 1'b0};
      mcnt <= mcnt + STEP_COUNT_WIDTH'(1);
      if (mcnt == STEP_COUNT_WIDTH'(WIDTH - 1)) begin
        case (mdest)
          MUL_REDUCE: base <= step;
          MUL_ACC:    acc <= step;
          default: begin
            base <= step;
            expo <= {1'b0, expo[EXP_WIDTH-1:1]};
          end
        endcase
      end
    end
  end

  assign status.mul_done = mul_done;
  assign status.exp_zero = (expo == '0);
  assign status.exp_lsb  = expo[0];
  assign status.mod_zero = (mod_q == '0);

  assign result   = acc;
  assign last_out = last_q;

endmodule

/* hdl/rme_controller.sv */
// Controller: sequences reduction, multiply and square steps of the exponentiation.
module rme_controller (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  output logic                 done,
  output rme_pkg::dp_cmd_t     cmd,
  input  rme_pkg::dp_status_t  status
);
  import rme_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SETUP,
    ST_RED_WAIT,
    ST_STEP,
    ST_ACC_WAIT,
    ST_SQ_WAIT,
    ST_FINISH
  } state_t;

  state_t   state;
  logic     mul_start;
  mul_sel_t mul_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      done      <= 1'b0;
      mul_start <= 1'b0;
      mul_sel   <= MUL_REDUCE;
    end else begin
      done      <= 1'b0;
      mul_start <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          state <= ST_SETUP;
        end
        ST_SETUP: begin
          // The trivial cases already hold their answer in the accumulator.
          if (status.exp_zero || status.mod_zero) begin
            state <= ST_FINISH;
          end else begin
            mul_start <= 1'b1;
            mul_sel   <= MUL_REDUCE;
            state     <= ST_RED_WAIT;
          end
        end
        ST_RED_WAIT: begin
          if (status.mul_done) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          if (status.exp_zero) begin
            state <= ST_FINISH;
          end else if (status.exp_lsb) begin
            mul_start <= 1'b1;
            mul_sel   <= MUL_ACC;
            state     <= ST_ACC_WAIT;
          end else begin
            mul_start <= 1'b1;
            mul_sel   <= MUL_SQUARE;
            state     <= ST_SQ_WAIT;
          end
        end
        ST_ACC_WAIT: begin
          if (status.mul_done) begin
            mul_start <= 1'b1;
            mul_sel   <= MUL_SQUARE;
            state     <= ST_SQ_WAIT;
          end
        end
        ST_SQ_WAIT: begin
          // The datapath shifts the exponent when the square is written back.
          if (status.mul_done) begin
            state <= ST_STEP;
          end
        end
        ST_FINISH: begin
          done  <= 1'b1;
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The datapath captures the transaction at the accepting edge itself.
  assign cmd = '{load: (state == ST_IDLE) && start, mul_start: mul_start, mul_sel: mul_sel};

  assign busy = (state != ST_IDLE);

endmodule

/* hdl/rsa_modular_exponentiation_core.sv */
// Each modular multiply is a start, 16 bit-serial steps and a done. A transaction loads,
// reduces the value mod m, then per exponent bit multiplies into the accumulator on a one
// bit and squares; exponent or modulus zero skips the multiplies and finishes at once.
// One transaction at a time: busy is low again in the done cycle, so start can be taken there.
// done is high for one cycle with result and last_out valid; the receiver cannot stall.
// Synchronous active-high reset returns the exponents and modulus to 5, 173 and 323.
module rsa_modular_exponentiation_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic                                action,
  input  logic [rme_pkg::WIDTH-1:0]           value,
  input  logic                                last_in,
  output logic                                done,
  output logic [rme_pkg::WIDTH-1:0]           result,
  output logic                                last_out,
  input  logic                                wr_en,
  input  logic [rme_pkg::CFG_INDEX_WIDTH-1:0] wr_index,
  input  logic [rme_pkg::WIDTH-1:0]           wr_data
);
  import rme_pkg::*;

  logic [EXP_WIDTH-1:0] public_exponent;
  logic [EXP_WIDTH-1:0] private_exponent;
  logic [WIDTH-1:0]     modulus;
  dp_cmd_t              cmd;
  dp_status_t           status;

  always_ff @(posedge clk) begin
    if (rst) begin
      public_exponent  <= PUBLIC_EXPONENT_RESET;
      private_exponent <= PRIVATE_EXPONENT_RESET;
      modulus          <= MODULUS_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_PUBLIC_EXPONENT:  public_exponent <= wr_data[EXP_WIDTH-1:0];
        REG_PRIVATE_EXPONENT: private_exponent <= wr_data[EXP_WIDTH-1:0];
        REG_MODULUS:          modulus <= wr_data;
        default: ;
      endcase
    end
  end

  rme_controller u_controller (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd),
    .status (status)
  );

  rme_datapath u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .public_exponent  (public_exponent),
    .private_exponent (private_exponent),
    .modulus          (modulus),
    .action           (action),
    .value            (value),
    .last_in          (last_in),
    .result           (result),
    .last_out         (last_out)
  );

endmodule

/* tb/rsa_modular_exponentiation_core_test.sv */
// Self-checking testbench for the RSA modular exponentiation core: directed table, then random phases.
module rsa_modular_exponentiation_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rme_pkg::*;

  // Index past the register list; the core must ignore writes to it.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
  localparam int PHASE_COUNT = 8;
  localparam int ITEMS_PER_PHASE = 125;
  localparam int SCRIPT_ROWS = 34;

  typedef enum logic { ROW_ITEM, ROW_WRITE } row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic                       act;
    logic [CFG_INDEX_WIDTH-1:0] idx;
    logic [WIDTH-1:0]           data;
    logic                       last;
    bit                         fixed;
    logic [WIDTH-1:0]           want;
  } row_t;

  typedef struct {
    logic [WIDTH-1:0] result;
    logic             last;
  } modexp_result_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       start = 1'b0;
  logic                       busy;
  logic                       action = ACTION_ENCRYPT;
  logic [WIDTH-1:0]           value = '0;
  logic                       last_in = 1'b0;
  logic                       done;
  logic [WIDTH-1:0]           result;
  logic                       last_out;
  logic                       wr_en = 1'b0;
  logic [CFG_INDEX_WIDTH-1:0] wr_index = REG_PUBLIC_EXPONENT;
  logic [WIDTH-1:0]           wr_data = '0;

  logic [EXP_WIDTH-1:0] cfg_public_exp = PUBLIC_EXPONENT_RESET;
  logic [EXP_WIDTH-1:0] cfg_private_exp = PRIVATE_EXPONENT_RESET;
  logic [WIDTH-1:0]     cfg_modulus = MODULUS_RESET;

  modexp_result_t pending_results[$];
  int error_count = 0;
  int idle_by_phase[4] = '{0, 46, 0, 11};

  row_t script[SCRIPT_ROWS] = '{
    '{ROW_ITEM,  ACTION_ENCRYPT, REG_UNUSED, 16'd0,      1'b0, 1'b1, 16'd0},
    '{ROW_ITEM,  ACTION_ENCRYPT, REG_UNUSED, 16'd1,      1'b1, 1'b1, 16'd1},
    '{ROW_ITEM,  ACTION_DECRYPT, REG_UNUSED, 16'd1,      1'b0, 1'b1, 16'd1},
    '{ROW_ITEM,  ACTION_ENCRYPT, REG_UNUSED, 16'd322,    1'b0, 1'b1, 16'd322},
    '{ROW_ITEM,  ACTION_DECRYPT, REG_UNUSED, 16'd322,    1'b1, 1'b1, 16'd322},
    '{ROW_ITEM,  ACTION_ENCRYPT, REG_UNUSED, 16'd323,    1'b0, 1'b1, 16'd0},
    '{ROW_ITEM,  ACTION_DECRYPT, REG_UNUSED, 16'd65535,  1'b1, 1'b0, 16'd0},
    '{ROW_ITEM,  ACTION_ENCRYPT, REG_UNUSED, 16'd65535,  1'b0, 1'b0, 16'd0},
    '{ROW_ITEM,  ACTION_ENCRYPT, REG_UNUSED, 16'd2,      1'b0, 1'b1, 16'd32},
    '{ROW_ITEM,  ACTION_DECRYPT, REG_UNUSED, 16'd12345,  1'b0, 1'b0, 16'd0},
    '{ROW_WRITE, ACTION_ENCRYPT, REG_PUBLIC_EXPONENT, 16'd0, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM,  ACTION_ENCRYPT, REG_UNUSED, 16'd65535,  1'b0, 1'b1, 16'd1},
    '{ROW_ITEM,  ACTION_ENCRYPT, REG_UNUSED, 16'd0,      1'b1, 1'b1, 16'd1},
    '{ROW_WRITE, ACTION_ENCRYPT, REG_MODULUS, 16'd1,     1'b0, 1'b0, 16'd0},
    '{ROW_ITEM,  ACTION_ENCRYPT, REG_UNUSED, 16'd7,      1'b0, 1'b1, 16'd1},
    '{ROW_ITEM,  ACTION_DECRYPT, REG_UNUSED, 16'd7,      1'b1, 1'b1, 16'd0},
    '{ROW_WRITE, ACTION_ENCRYPT, REG_MODULUS, 16'd0,     1'b0, 1'b0, 16'd0},
    '{ROW_ITEM,  ACTION_DECRYPT, REG_UNUSED, 16'd7,      1'b0, 1'b1, 16'd0},
    '{ROW_ITEM,  ACTION_ENCRYPT, REG_UNUSED, 16'd7,      1'b1, 1'b1, 16'd1},
    '{ROW_WRITE, ACTION_ENCRYPT, REG_UNUSED, 16'hFFFF,   1'b0, 1'b0, 16'd0},
    '{ROW_ITEM,  ACTION_DECRYPT, REG_UNUSED, 16'd9,      1'b0, 1'b1, 16'd0},
    '{ROW_WRITE, ACTION_ENCRYPT, REG_MODULUS, 16'd65535, 1'b0, 1'b0, 16'd0},
    '{ROW_WRITE, ACTION_ENCRYPT, REG_PUBLIC_EXPONENT, 16'd65535, 1'b0, 1'b0, 16'd0},
    '{ROW_WRITE, ACTION_ENCRYPT, REG_PRIVATE_EXPONENT, 16'd65535, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM,  ACTION_ENCRYPT, REG_UNUSED, 16'd65534,  1'b0, 1'b1, 16'd65534},
    '{ROW_ITEM,  ACTION_DECRYPT, REG_UNUSED, 16'd65535,  1'b1, 1'b1, 16'd0},
    '{ROW_ITEM,  ACTION_ENCRYPT, REG_UNUSED, 16'hAAAA,   1'b0, 1'b0, 16'd0},
    '{ROW_ITEM,  ACTION_DECRYPT, REG_UNUSED, 16'h5555,   1'b1, 1'b0, 16'd0},
    '{ROW_WRITE, ACTION_ENCRYPT, REG_PRIVATE_EXPONENT, 16'd1, 1'b0, 1'b0, 16'd0},
    '{ROW_WRITE, ACTION_ENCRYPT, REG_PUBLIC_EXPONENT, 16'd2, 1'b0, 1'b0, 16'd0},
    '{ROW_ITEM,  ACTION_DECRYPT, REG_UNUSED, 16'd40000,  1'b0, 1'b1, 16'd40000},
    '{ROW_ITEM,  ACTION_ENCRYPT, REG_UNUSED, 16'd300,    1'b0, 1'b0, 16'd0},
    '{ROW_WRITE, ACTION_ENCRYPT, REG_MODULUS, 16'd2,     1'b0, 1'b0, 16'd0},
    '{ROW_ITEM,  ACTION_DECRYPT, REG_UNUSED, 16'd65535,  1'b1, 1'b1, 16'd1}
  };

  rsa_modular_exponentiation_core dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .action   (action),
    .value    (value),
    .last_in  (last_in),
    .done     (done),
    .result   (result),
    .last_out (last_out),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Square-and-multiply; products of two residues fit in 32 bits.
  function automatic logic [WIDTH-1:0] modpow(logic [WIDTH-1:0] base,
                                              logic [EXP_WIDTH-1:0] expo,
                                              logic [WIDTH-1:0] m);
    logic [31:0]          acc;
    logic [31:0]          sq;
    logic [EXP_WIDTH-1:0] e;
    if (expo == '0) return 16'd1;
    if (m == '0) return 16'd0;
    acc = 32'd1 % m;
    sq = base % m;
    e = expo;
    while (e != '0) begin
      if (e[0]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
      e = e >> 1;
    end
    return acc[WIDTH-1:0];
  endfunction

  task automatic report_mismatch(string what, logic [WIDTH-1:0] got, logic [WIDTH-1:0] want);
    error_count++;
    $display("%0t ns: %s mismatch: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Wait until the core has returned everything and gone idle.
  task automatic settle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, logic [WIDTH-1:0] data);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= data;
    @(posedge clk);
    case (idx)
      REG_PUBLIC_EXPONENT:  cfg_public_exp = data;
      REG_PRIVATE_EXPONENT: cfg_private_exp = data;
      REG_MODULUS:          cfg_modulus = data;
      default: ;
    endcase
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(logic act, logic [WIDTH-1:0] val, logic lst,
                           bit fixed, logic [WIDTH-1:0] want, int idle_pct);
    int             gap;
    modexp_result_t entry;
    gap = 0;
    if (idle_pct > 0) begin
      while ($urandom_range(0, 99) < idle_pct) gap++;
      // Now and then a long pause, so the next start also comes long after the core went idle.
      if ($urandom_range(0, 19) == 0) gap += $urandom_range(1, 700);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    value <= val;
    last_in <= lst;
    @(posedge clk);
    while (busy) @(posedge clk);
    entry.result = fixed ? want
                 : modpow(val, (act == ACTION_DECRYPT) ? cfg_private_exp : cfg_public_exp,
                          cfg_modulus);
    entry.last = lst;
    pending_results.push_back(entry);
  endtask

  function automatic logic [WIDTH-1:0] pick_value(logic [WIDTH-1:0] m);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) begin
      case ($urandom_range(0, 4))
        0: return 16'd0;
        1: return 16'd1;
        2: return m - 16'd1;
        3: return m;
        default: return 16'hFFFF;
      endcase
    end
    if (sel <= 2 && m != '0) return WIDTH'($urandom_range(0, m - 1));
    return WIDTH'($urandom);
  endfunction

  always @(posedge clk) begin
    modexp_result_t exp_item;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with no transaction pending", result, 16'd0);
      end else begin
        exp_item = pending_results.pop_front();
        if (result !== exp_item.result) report_mismatch("result", result, exp_item.result);
        if (last_out !== exp_item.last) begin
          report_mismatch("last_out", WIDTH'(last_out), WIDTH'(exp_item.last));
        end
      end
    end
  end

  initial begin
    logic [EXP_WIDTH-1:0] pub;
    logic [EXP_WIDTH-1:0] priv;
    logic [WIDTH-1:0]     modv;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].kind == ROW_WRITE) begin
        settle();
        write_reg(script[i].idx, script[i].data);
      end else begin
        send_item(script[i].act, script[i].data, script[i].last,
                  script[i].fixed, script[i].want, 0);
      end
    end

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      pub = EXP_WIDTH'($urandom);
      priv = EXP_WIDTH'($urandom);
      modv = WIDTH'($urandom);
      case (ph)
        0: begin
          pub = PUBLIC_EXPONENT_RESET;
          priv = PRIVATE_EXPONENT_RESET;
          modv = MODULUS_RESET;
        end
        1: begin
          pub = 16'hFFFF;
          priv = 16'hFFFF;
          modv = 16'hFFFF;
        end
        3: pub = '0;
        4: modv = 16'd1;
        5: begin
          modv = '0;
          priv = '0;
        end
        6: modv = modv | 16'h8000;
        7: begin
          pub = 16'd1;
          priv = 16'd3;
        end
        default: ;
      endcase
      settle();
      write_reg(REG_PUBLIC_EXPONENT, pub);
      write_reg(REG_PRIVATE_EXPONENT, priv);
      write_reg(REG_MODULUS, modv);
      write_reg(REG_UNUSED, WIDTH'($urandom));
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(1'($urandom_range(0, 1)), pick_value(cfg_modulus),
                  $urandom_range(0, 3) == 0, 1'b0, 16'd0, idle_by_phase[ph % 4]);
      end
    end

    settle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
